### src/assert_macros.svh
// Assertion macros used by the RTL of the drift profile interpolator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/zdpi_pkg.sv
// Types, widths and node tables of the zero drift profile interpolator.
`default_nettype none

package zdpi_pkg;

   localparam int TABLE_LEN = 21;
   localparam int IDX_W     = 5;    // addresses every node of the table
   localparam int TIME_W    = 32;
   localparam int LEVEL_W   = 15;
   localparam int DIFF_W    = 13;   // signed level step between neighbors
   localparam int DELTA_W   = 17;   // widest segment is 80000 ms
   localparam int PROD_W    = DIFF_W + DELTA_W + 1;
   localparam int MAG_W     = 29;   // rounded product magnitude
   localparam int QUO_W     = 12;   // quotient never exceeds the level step

   typedef logic [TIME_W-1:0]  time_type;
   typedef logic [LEVEL_W-1:0] level_type;

   localparam time_type NODE_TIME [TABLE_LEN] = '{
      32'd0,      32'd1000,   32'd2000,   32'd3000,   32'd4000,   32'd5000,
      32'd6000,   32'd8000,   32'd10000,  32'd15000,  32'd20000,  32'd30000,
      32'd45000,  32'd60000,  32'd75000,  32'd90000,  32'd120000, 32'd150000,
      32'd180000, 32'd220000, 32'd300000
   };

   localparam level_type NODE_LEVEL [TABLE_LEN] = '{
      15'd16223, 15'd15286, 15'd15200, 15'd15155, 15'd15099, 15'd15053,
      15'd15048, 15'd14953, 15'd14966, 15'd15296, 15'd15424, 15'd15614,
      15'd16016, 15'd16319, 15'd16606, 15'd16800, 15'd17670, 15'd18540,
      15'd19410, 15'd20570, 15'd22890
   };

endpackage

`default_nettype wire

### src/zero_drift_profile_interpolator_unit.sv
// Pipelined piecewise linear lookup of the sensor zero level over elapsed time.
//
//   channel  dir  handshake           word contents (lowest bit first)
//   req      in   req_tvalid/tready   tdata[31:0]  uptime_ms
//   rsp      out  rsp_tvalid/tready   tdata[14:0]  zero_level, tdata[15] zero
//
// One word enters per cycle while rsp is not stalled; each word passes in
// order through the segment search, table read, multiply, rounding,
// a 12-stage restoring divider (one quotient bit per stage) and the
// output register. A stall on rsp freezes every stage at once, so nothing
// is dropped or repeated. Synchronous active-high reset clears the valid
// bits; payload registers carry no reset.
`default_nettype none
`include "assert_macros.svh"

module zero_drift_profile_interpolator_unit #(
   parameter int NODE_COUNT = 21
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] uptime_ms
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // [14:0] zero_level, [15] zero
);

   localparam int NODES = (NODE_COUNT > zdpi_pkg::TABLE_LEN) ? zdpi_pkg::TABLE_LEN :
                          ((NODE_COUNT < 2) ? 2 : NODE_COUNT);
   localparam int QW    = zdpi_pkg::QUO_W;
   localparam int MW    = zdpi_pkg::MAG_W;
   localparam int DW    = zdpi_pkg::DELTA_W;

   // Whole pipe moves together; hold everything while the output word waits.
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // ---------------- stage A: segment search ----------------
   logic                         a_vld_ff, a_vld_in;
   zdpi_pkg::time_type           a_t_ff;
   logic                         a_low_ff, a_low_in;
   logic                         a_high_ff, a_high_in;
   logic [zdpi_pkg::IDX_W-1:0]   a_idx_ff, a_idx_in;

   always_comb begin
      a_vld_in  = req_tvalid;
      a_low_in  = req_tdata <= zdpi_pkg::NODE_TIME[0];
      a_high_in = req_tdata >= zdpi_pkg::NODE_TIME[NODES-1];
      // Times rise, so the last node below the input marks the segment start.
      a_idx_in  = '0;
      for (int j = 1; j < zdpi_pkg::TABLE_LEN - 1; j++) begin
         if (j <= NODES - 2 && req_tdata > zdpi_pkg::NODE_TIME[j]) begin
            a_idx_in = zdpi_pkg::IDX_W'(j);
         end
      end
   end

   // ---------------- stage B: table read ----------------
   logic                         b_vld_ff;
   zdpi_pkg::level_type          b_base_ff, b_base_in;
   logic signed [zdpi_pkg::DIFF_W-1:0] b_diff_ff, b_diff_in;
   logic [DW-1:0]                b_delta_ff, b_delta_in;
   logic [DW-1:0]                b_span_ff, b_span_in;
   zdpi_pkg::time_type           lo_time, hi_time, span_full, delta_full;
   zdpi_pkg::level_type          lo_lvl, hi_lvl;
   logic signed [zdpi_pkg::LEVEL_W:0] diff_full;
   logic [zdpi_pkg::IDX_W-1:0]   a_idx_next;

   always_comb begin
      a_idx_next = a_idx_ff + zdpi_pkg::IDX_W'(1);
      lo_time    = zdpi_pkg::NODE_TIME[a_idx_ff];
      hi_time    = zdpi_pkg::NODE_TIME[a_idx_next];
      lo_lvl     = zdpi_pkg::NODE_LEVEL[a_idx_ff];
      hi_lvl     = zdpi_pkg::NODE_LEVEL[a_idx_next];
      span_full  = hi_time - lo_time;
      delta_full = a_t_ff - lo_time;
      diff_full  = $signed({1'b0, hi_lvl}) - $signed({1'b0, lo_lvl});
      b_span_in  = span_full[DW-1:0];
      // Clamped ends run through the divider with a zero step.
      priority if (a_low_ff) begin
         b_base_in  = zdpi_pkg::NODE_LEVEL[0];
         b_diff_in  = '0;
         b_delta_in = '0;
      end else if (a_high_ff) begin
         b_base_in  = zdpi_pkg::NODE_LEVEL[NODES-1];
         b_diff_in  = '0;
         b_delta_in = '0;
      end else begin
         b_base_in  = lo_lvl;
         b_diff_in  = diff_full[zdpi_pkg::DIFF_W-1:0];
         b_delta_in = delta_full[DW-1:0];
      end
   end

   // ---------------- stage C: multiply ----------------
   logic                               c_vld_ff;
   logic signed [zdpi_pkg::PROD_W-1:0] c_prod_ff;
   zdpi_pkg::level_type                c_base_ff;
   logic [DW-1:0]                      c_span_ff;

   // ---------------- stage D: round half away from zero ----------------
   logic                               d_vld_ff;
   logic                               d_neg_ff, d_neg_in;
   logic [MW-1:0]                      d_mag_ff, d_mag_in;
   zdpi_pkg::level_type                d_base_ff;
   logic [DW-1:0]                      d_span_ff;
   logic [zdpi_pkg::PROD_W-1:0]        prod_abs;

   always_comb begin
      d_neg_in = c_prod_ff[zdpi_pkg::PROD_W-1];
      prod_abs = d_neg_in ? -c_prod_ff : c_prod_ff;
      d_mag_in = MW'(prod_abs) + MW'(c_span_ff >> 1);
   end

   // ---------------- divider: one quotient bit per stage ----------------
   logic                div_vld_ff  [QW];
   logic                div_neg_ff  [QW];
   logic [MW-1:0]       div_rem_ff  [QW];
   logic [MW-1:0]       div_rem_in  [QW];
   logic [QW-1:0]       div_quo_ff  [QW];
   logic [QW-1:0]       div_quo_in  [QW];
   logic [DW-1:0]       div_span_ff [QW];
   zdpi_pkg::level_type div_base_ff [QW];
   logic                src_vld     [QW];
   logic                src_neg     [QW];
   logic [MW-1:0]       src_rem     [QW];
   logic [QW-1:0]       src_quo     [QW];
   logic [DW-1:0]       src_span    [QW];
   zdpi_pkg::level_type src_base    [QW];

   always_comb begin
      src_vld[0]  = d_vld_ff;
      src_neg[0]  = d_neg_ff;
      src_rem[0]  = d_mag_ff;
      src_quo[0]  = '0;
      src_span[0] = d_span_ff;
      src_base[0] = d_base_ff;
      for (int k = 1; k < QW; k++) begin
         src_vld[k]  = div_vld_ff[k-1];
         src_neg[k]  = div_neg_ff[k-1];
         src_rem[k]  = div_rem_ff[k-1];
         src_quo[k]  = div_quo_ff[k-1];
         src_span[k] = div_span_ff[k-1];
         src_base[k] = div_base_ff[k-1];
      end
   end

   always_comb begin
      logic [MW-1:0] dvs;
      for (int k = 0; k < QW; k++) begin
         dvs = MW'(src_span[k]) << (QW - 1 - k);
         if (src_rem[k] >= dvs) begin
            div_rem_in[k] = src_rem[k] - dvs;
            div_quo_in[k] = src_quo[k] | (QW'(1) << (QW - 1 - k));
         end else begin
            div_rem_in[k] = src_rem[k];
            div_quo_in[k] = src_quo[k];
         end
      end
   end

   // ---------------- output: apply sign and add base ----------------
   logic                       out_vld_ff;
   logic [15:0]                out_data_ff, out_data_in;
   logic [zdpi_pkg::LEVEL_W:0] level_sum;

   always_comb begin
      if (div_neg_ff[QW-1]) begin
         level_sum = {1'b0, div_base_ff[QW-1]} - (zdpi_pkg::LEVEL_W+1)'(div_quo_ff[QW-1]);
      end else begin
         level_sum = {1'b0, div_base_ff[QW-1]} + (zdpi_pkg::LEVEL_W+1)'(div_quo_ff[QW-1]);
      end
      out_data_in = {1'b0, level_sum[zdpi_pkg::LEVEL_W-1:0]};
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   // Valid bits: clear on reset, advance with the pipe.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
         d_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
         for (int k = 0; k < QW; k++) begin
            div_vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         a_vld_ff   <= a_vld_in;
         b_vld_ff   <= a_vld_ff;
         c_vld_ff   <= b_vld_ff;
         d_vld_ff   <= c_vld_ff;
         out_vld_ff <= div_vld_ff[QW-1];
         for (int k = 0; k < QW; k++) begin
            div_vld_ff[k] <= src_vld[k];
         end
      end
   end

   // Payload: no reset, load on advance.
   always_ff @(posedge clock) begin
      if (adv) begin
         a_t_ff      <= req_tdata;
         a_low_ff    <= a_low_in;
         a_high_ff   <= a_high_in;
         a_idx_ff    <= a_idx_in;
         b_base_ff   <= b_base_in;
         b_diff_ff   <= b_diff_in;
         b_delta_ff  <= b_delta_in;
         b_span_ff   <= b_span_in;
         c_prod_ff   <= b_diff_ff * $signed({1'b0, b_delta_ff});
         c_base_ff   <= b_base_ff;
         c_span_ff   <= b_span_ff;
         d_neg_ff    <= d_neg_in;
         d_mag_ff    <= d_mag_in;
         d_base_ff   <= c_base_ff;
         d_span_ff   <= c_span_ff;
         out_data_ff <= out_data_in;
         for (int k = 0; k < QW; k++) begin
            div_neg_ff[k]  <= src_neg[k];
            div_rem_ff[k]  <= div_rem_in[k];
            div_quo_ff[k]  <= div_quo_in[k];
            div_span_ff[k] <= src_span[k];
            div_base_ff[k] <= src_base[k];
         end
      end
   end

   // ---------------- checks ----------------
   logic req_accept;
   logic clamp_ok;
   logic div_in_ok;
   logic div_out_ok;

   assign req_accept = req_tvalid && req_tready;
   assign clamp_ok   = !(a_vld_ff && a_low_ff && a_high_ff);
   assign div_in_ok  = !d_vld_ff || ((d_mag_ff >> QW) < MW'(d_span_ff));
   assign div_out_ok = !div_vld_ff[QW-1] || (div_rem_ff[QW-1] < MW'(div_span_ff[QW-1]));

   `ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_accept, a_vld_ff, "word lost at stage A")
   `ASSERT_ALWAYS(a_clamp_exclusive, clock, reset, clamp_ok, "both clamp flags set")
   `ASSERT_ALWAYS(div_input_fits, clock, reset, div_in_ok, "dividend overflows quotient width")
   `ASSERT_ALWAYS(div_rem_below_span, clock, reset, div_out_ok, "remainder not below span")

endmodule

`default_nettype wire
